// ===== design/reachability_closure_engine_core_macros.svh =====
// Assertion macros shared by the reachability closure engine checkers.
// No dependencies; included by files that hold concurrent assertions.
`ifndef REACHABILITY_CLOSURE_ENGINE_CORE_MACROS_SVH
`define REACHABILITY_CLOSURE_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RCE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rce_pkg.sv =====
// Shared types, constants and helpers of the reachability closure engine.
// No dependencies; imported by every module of the block but rce_ram.
package rce_pkg;

    localparam int VERTEX_CAP   = 64;
    localparam int ROW_W        = VERTEX_CAP;
    localparam int VIDX_W       = $clog2(VERTEX_CAP);
    localparam int CNT_W        = $clog2(VERTEX_CAP + 1);
    localparam int EDGE_W       = 13;
    localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_CLOSE  = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_A,
        ST_INS_B,
        ST_COPY,
        ST_PIVOT,
        ST_PLOAD,
        ST_ROW,
        ST_Q_A,
        ST_Q_B,
        ST_DONE
    } state_t;

    // One write request into a row memory
    typedef struct packed {
        logic              en;
        logic [VIDX_W-1:0] addr;
        logic [ROW_W-1:0]  data;
    } ram_wr_t;

    // One finished result
    typedef struct packed {
        logic              fwd;
        logic              bwd;
        logic              err;
        logic [EDGE_W-1:0] edges;
    } res_t;

    // Vertex count in use: register value clamped to 1..VERTEX_CAP
    function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] vc);
        logic [CNT_W-1:0] n;
        n = vc;
        if (vc == '0)
            n = CNT_W'(1);
        else if (vc > CNT_W'(VERTEX_CAP))
            n = CNT_W'(VERTEX_CAP);
        return n;
    endfunction

    function automatic logic [ROW_W-1:0] row_bit(input logic [VIDX_W-1:0] idx);
        return ROW_W'(1) << idx;
    endfunction

endpackage

// ===== design/reachability_closure_engine_core.sv =====
// Every result passes through one output register stage.
// One item at a time; the closure sweep reads one closure row per cycle while it walks the rows for one pivot.
// A new item is taken while the previous result waits in the output register.
// Reset (rst_n, async low) clears control, edge count, adjacency row valid bits
// and the closure-valid flag at once; vertex_count returns to 64, no clearing pass.
module reachability_closure_engine_core
    import rce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] vertex_a, [11:6] vertex_b, rest zero
    input  logic [2:0]  s_tuser,   // [1:0] mode, [2] two_way
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] reach_forward, [1] reach_backward,
                                   // [3:2] answer_code, [16:4] edge_total, rest zero
    output logic [0:0]  m_tuser,   // [0] range_error
    // vertex_count register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    ram_wr_t           adj_wr, clo_wr;
    logic [VIDX_W-1:0] adj_raddr, clo_raddr;
    logic [ROW_W-1:0]  adj_rdata, clo_rdata;
    logic              res_valid, res_take;
    res_t              res;
    logic              out_valid_reg;
    res_t              out_reg;

    rce_ram #(.DEPTH(VERTEX_CAP), .WIDTH(ROW_W)) u_adj_ram (
        .clk   (clk),
        .we    (adj_wr.en),
        .waddr (adj_wr.addr),
        .wdata (adj_wr.data),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    rce_ram #(.DEPTH(VERTEX_CAP), .WIDTH(ROW_W)) u_clo_ram (
        .clk   (clk),
        .we    (clo_wr.en),
        .waddr (clo_wr.addr),
        .wdata (clo_wr.data),
        .raddr (clo_raddr),
        .rdata (clo_rdata)
    );

    rce_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (mode_t'(s_tuser[1:0])),
        .in_a      (s_tdata[5:0]),
        .in_b      (s_tdata[11:6]),
        .in_two    (s_tuser[2]),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .adj_wr    (adj_wr),
        .adj_raddr (adj_raddr),
        .adj_rdata (adj_rdata),
        .clo_wr    (clo_wr),
        .clo_raddr (clo_raddr),
        .clo_rdata (clo_rdata),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // output register takes a result when empty or being drained
    assign res_take = res_valid && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.edges, out_reg.fwd, out_reg.bwd,
                       out_reg.bwd, out_reg.fwd};
    assign m_tuser  = out_reg.err;

endmodule

// ===== design/rce_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Write-first on a same-address collision. Depends on nothing.
module rce_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read port, forwarding a write to the same entry
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
            rdata_reg <= wdata;
        else
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rce_seq.sv =====
// Sequencer of the reachability closure engine: edge loading and closure sweep
// as read-modify-write on the two row memories, queries as reads. Uses rce_pkg.
module rce_seq
    import rce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input request
    input  logic              in_valid,
    output logic              in_ready,
    input  mode_t             in_mode,
    input  logic [VIDX_W-1:0] in_a,
    input  logic [VIDX_W-1:0] in_b,
    input  logic              in_two,
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data,
    // adjacency memory
    output ram_wr_t           adj_wr,
    output logic [VIDX_W-1:0] adj_raddr,
    input  logic [ROW_W-1:0]  adj_rdata,
    // closure memory
    output ram_wr_t           clo_wr,
    output logic [VIDX_W-1:0] clo_raddr,
    input  logic [ROW_W-1:0]  clo_rdata,
    // result
    output logic              res_valid,
    input  logic              res_take,
    output res_t              res
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  vc_reg, vc_next;
    logic [EDGE_W-1:0] edges_reg, edges_next;
    logic [ROW_W-1:0]  avalid_reg, avalid_next;
    logic              clo_live_reg, clo_live_next;
    logic [VIDX_W-1:0] a_reg, a_next;
    logic [VIDX_W-1:0] b_reg, b_next;
    logic              two_reg, two_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  s_reg, s_next;
    logic              pend_reg, pend_next;
    logic [VIDX_W-1:0] prow_reg, prow_next;
    logic [ROW_W-1:0]  pivot_reg, pivot_next;
    logic              fwd_reg, fwd_next;
    logic              bwd_reg, bwd_next;
    logic              err_reg, err_next;

    logic [CNT_W-1:0]  n;
    logic              in_bad;
    logic [ROW_W-1:0]  adj_row;
    logic [ROW_W-1:0]  copy_row;

    assign n        = active_count(vc_reg);
    assign in_bad   = ({1'b0, in_a} >= n) || ({1'b0, in_b} >= n);
    // adjacency row on the read port: row b in ST_INS_B, row a otherwise
    assign adj_row  = avalid_reg[(state_reg == ST_INS_B) ? b_reg : a_reg] ? adj_rdata : '0;
    assign copy_row = (avalid_reg[prow_reg] ? adj_rdata : '0) | row_bit(prow_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            vc_reg       <= CNT_W'(VERTEX_CAP);
            edges_reg    <= '0;
            avalid_reg   <= '0;
            clo_live_reg <= 1'b0;
            k_reg        <= '0;
            s_reg        <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            vc_reg       <= vc_next;
            edges_reg    <= edges_next;
            avalid_reg   <= avalid_next;
            clo_live_reg <= clo_live_next;
            k_reg        <= k_next;
            s_reg        <= s_next;
            pend_reg     <= pend_next;
        end
    end

    // item payload and working rows
    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        two_reg   <= two_next;
        prow_reg  <= prow_next;
        pivot_reg <= pivot_next;
        fwd_reg   <= fwd_next;
        bwd_reg   <= bwd_next;
        err_reg   <= err_next;
    end

    // next state and memory requests
    always_comb
    begin
        state_next    = state_reg;
        vc_next       = vc_reg;
        edges_next    = edges_reg;
        avalid_next   = avalid_reg;
        clo_live_next = clo_live_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        two_next      = two_reg;
        k_next        = k_reg;
        s_next        = s_reg;
        pend_next     = pend_reg;
        prow_next     = prow_reg;
        pivot_next    = pivot_reg;
        fwd_next      = fwd_reg;
        bwd_next      = bwd_reg;
        err_next      = err_reg;
        in_ready      = 1'b0;
        cfg_ready     = 1'b0;
        res_valid     = 1'b0;
        adj_wr        = '0;
        clo_wr        = '0;
        adj_raddr     = a_reg;
        clo_raddr     = a_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cfg_ready = 1'b1;
                adj_raddr = in_a;
                clo_raddr = in_a;
                if (cfg_valid)
                begin
                    // new graph: drop all rows and the count
                    vc_next       = cfg_data;
                    avalid_next   = '0;
                    clo_live_next = 1'b0;
                    edges_next    = '0;
                end
                if (in_valid)
                begin
                    a_next   = in_a;
                    b_next   = in_b;
                    two_next = in_two;
                    fwd_next = 1'b0;
                    bwd_next = 1'b0;
                    err_next = 1'b0;
                    case (in_mode)
                        MODE_INSERT:
                        begin
                            err_next   = in_bad;
                            state_next = in_bad ? ST_DONE : ST_INS_A;
                        end
                        MODE_CLOSE:
                        begin
                            s_next        = '0;
                            pend_next     = 1'b0;
                            clo_live_next = 1'b1;
                            state_next    = ST_COPY;
                        end
                        MODE_QUERY:
                        begin
                            err_next   = in_bad;
                            state_next = in_bad ? ST_DONE : ST_Q_A;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // forward edge: row a gets bit b
            ST_INS_A:
            begin
                adj_raddr = b_reg;
                if (!adj_row[b_reg])
                begin
                    adj_wr.en          = 1'b1;
                    adj_wr.addr        = a_reg;
                    adj_wr.data        = adj_row | row_bit(b_reg);
                    avalid_next[a_reg] = 1'b1;
                    if (edges_reg != EDGE_MAX)
                        edges_next = edges_reg + EDGE_W'(1);
                end
                state_next = two_reg ? ST_INS_B : ST_DONE;
            end

            // reverse edge: row b gets bit a
            ST_INS_B:
            begin
                adj_raddr = b_reg;
                if (!adj_row[a_reg])
                begin
                    adj_wr.en          = 1'b1;
                    adj_wr.addr        = b_reg;
                    adj_wr.data        = adj_row | row_bit(a_reg);
                    avalid_next[b_reg] = 1'b1;
                    if (edges_reg != EDGE_MAX)
                        edges_next = edges_reg + EDGE_W'(1);
                end
                state_next = ST_DONE;
            end

            // copy adjacency rows into closure with self loops
            ST_COPY:
            begin
                adj_raddr = s_reg[VIDX_W-1:0];
                if (pend_reg)
                begin
                    clo_wr.en   = 1'b1;
                    clo_wr.addr = prow_reg;
                    clo_wr.data = copy_row;
                end
                if (s_reg < n)
                begin
                    s_next    = s_reg + CNT_W'(1);
                    pend_next = 1'b1;
                    prow_next = s_reg[VIDX_W-1:0];
                end
                else
                begin
                    pend_next  = 1'b0;
                    k_next     = '0;
                    state_next = ST_PIVOT;
                end
            end

            // fetch pivot row k
            ST_PIVOT:
            begin
                clo_raddr  = k_reg[VIDX_W-1:0];
                state_next = ST_PLOAD;
            end

            ST_PLOAD:
            begin
                pivot_next = clo_rdata;
                s_next     = '0;
                pend_next  = 1'b0;
                state_next = ST_ROW;
            end

            // sweep rows: a row holding bit k takes in the pivot row
            ST_ROW:
            begin
                clo_raddr = s_reg[VIDX_W-1:0];
                if (pend_reg && clo_rdata[k_reg[VIDX_W-1:0]])
                begin
                    clo_wr.en   = 1'b1;
                    clo_wr.addr = prow_reg;
                    clo_wr.data = clo_rdata | pivot_reg;
                end
                if (s_reg < n)
                begin
                    s_next    = s_reg + CNT_W'(1);
                    pend_next = 1'b1;
                    prow_next = s_reg[VIDX_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                    if ((k_reg + CNT_W'(1)) < n)
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_PIVOT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            // row a is on the port; fetch row b (closure reads zero until a close)
            ST_Q_A:
            begin
                clo_raddr  = b_reg;
                fwd_next   = clo_live_reg && clo_rdata[b_reg];
                state_next = ST_Q_B;
            end

            ST_Q_B:
            begin
                clo_raddr  = b_reg;
                bwd_next   = clo_live_reg && clo_rdata[a_reg];
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.fwd   = fwd_reg;
    assign res.bwd   = bwd_reg;
    assign res.err   = err_reg;
    assign res.edges = edges_reg;

endmodule

// ===== design/rce_checker.sv =====
// Port-level checker of the reachability closure engine, bound to the top.
// Uses rce_pkg and the assertion macros header.
`include "reachability_closure_engine_core_macros.svh"

module rce_checker
    import rce_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [6:0]  cfg_data
);

    // a stalled result holds
    `RCE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    // answer code is 2*forward + backward
    `RCE_ASSERT_IMPL(a_code, clk, rst_n, m_tvalid, (m_tdata[3] == m_tdata[0]) && (m_tdata[2] == m_tdata[1]), "answer code mismatch")
    // a range error never reports reachability
    `RCE_ASSERT_IMPL(a_err_quiet, clk, rst_n, m_tvalid && m_tuser[0], m_tdata[3:0] == 4'd0, "reach set with range error")
    // an item with a result keeps the input closed in the next cycle
    `RCE_ASSERT_NEXT(a_busy, clk, rst_n, s_tvalid && s_tready && (s_tuser[1:0] != MODE_NONE), !s_tready, "input open while busy")

endmodule

bind reachability_closure_engine_core rce_checker u_rce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

// ===== tb/sv/closure_watch.sv =====
`timescale 1ns / 100ps
// Predicts and checks the reachability closure engine's results from its three channels.
// Depends on rce_pkg for the mode codes and widths. Instantiated by the testbench top.
module closure_watch
    import rce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] vertex_a, [11:6] vertex_b
    input  logic [2:0]  s_tuser,   // [1:0] mode, [2] two_way
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [0] fwd, [1] bwd, [3:2] code, [16:4] edge_total
    input  logic [0:0]  m_tuser,   // [0] range_error
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    output int          mismatch_total,
    output int          requests_open
);

    typedef struct packed {
        logic              fwd;
        logic              bwd;
        logic [1:0]        code;
        logic [EDGE_W-1:0] edges;
        logic              err;
    } reach_t;

    // Shadow copy of the graph, its closure and the vertex count register
    logic [ROW_W-1:0]  adj_rows   [VERTEX_CAP];
    logic [ROW_W-1:0]  reach_rows [VERTEX_CAP];
    logic [EDGE_W-1:0] edge_count;
    logic [6:0]        vcount_reg;
    reach_t            answer_q [$];
    int                fails = 0;

    function automatic int vertices_in_use();
        if (vcount_reg == 7'd0)
            return 1;
        if (vcount_reg > 7'(VERTEX_CAP))
            return VERTEX_CAP;
        return int'(vcount_reg);
    endfunction

    task automatic clear_graph();
        int r;
        for (r = 0; r < VERTEX_CAP; r++)
        begin
            adj_rows[r]   = '0;
            reach_rows[r] = '0;
        end
        edge_count = '0;
    endtask

    // A new directed edge bumps the count, which sticks at its top value
    task automatic add_edge(input int src, input int dst);
        if (!adj_rows[src][dst])
        begin
            if (edge_count != EDGE_MAX)
                edge_count++;
            adj_rows[src][dst] = 1'b1;
        end
    endtask

    // Warshall closure: self loops first, then row s absorbs row k when s reaches k
    task automatic run_closure(input int n);
        int r;
        int k;
        for (r = 0; r < VERTEX_CAP; r++)
            reach_rows[r] = adj_rows[r];
        for (r = 0; r < n; r++)
            reach_rows[r][r] = 1'b1;
        for (k = 0; k < n; k++)
            for (r = 0; r < n; r++)
                if (reach_rows[r][k])
                    reach_rows[r] |= reach_rows[k];
    endtask

    task automatic predict(input mode_t md, input int a, input int b, input logic two,
                           output reach_t res);
        int   n;
        logic oob;
        n   = vertices_in_use();
        oob = (a >= n) || (b >= n);
        res = '0;
        case (md)
            MODE_INSERT:
            begin
                if (oob)
                    res.err = 1'b1;
                else
                begin
                    add_edge(a, b);
                    if (two)
                        add_edge(b, a);
                end
            end
            MODE_CLOSE:
                run_closure(n);
            default:
            begin
                if (oob)
                    res.err = 1'b1;
                else
                begin
                    res.fwd = reach_rows[a][b];
                    res.bwd = reach_rows[b][a];
                end
            end
        endcase
        res.code  = {res.fwd, res.bwd};
        res.edges = edge_count;
    endtask

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want_v, got_v);
            fails++;
        end
    endtask

    // Results are retired before new requests are predicted, also when both share a cycle
    always @(posedge clk or negedge rst_n)
    begin : watch
        reach_t seen;
        reach_t want;
        if (!rst_n)
        begin
            clear_graph();
            vcount_reg = 7'd64;
            answer_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.fwd   = m_tdata[0];
                seen.bwd   = m_tdata[1];
                seen.code  = m_tdata[3:2];
                seen.edges = m_tdata[16:4];
                seen.err   = m_tuser[0];
                if (answer_q.size() == 0)
                begin
                    $error("result with no request outstanding: edge_total %0d", seen.edges);
                    fails++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    check_field("reach_forward", want.fwd, seen.fwd);
                    check_field("reach_backward", want.bwd, seen.bwd);
                    check_field("answer_code", want.code, seen.code);
                    check_field("edge_total", want.edges, seen.edges);
                    check_field("range_error", want.err, seen.err);
                end
            end
            // A count write starts a fresh graph
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg = cfg_data;
                clear_graph();
            end
            if (s_tvalid && s_tready && mode_t'(s_tuser[1:0]) != MODE_NONE)
            begin
                predict(mode_t'(s_tuser[1:0]), int'(s_tdata[5:0]), int'(s_tdata[11:6]),
                        s_tuser[2], want);
                answer_q.push_back(want);
            end
        end
        mismatch_total <= fails;
        requests_open  <= answer_q.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the reachability closure engine testbench: clock, reset, stimulus and verdict.
// Depends on rce_pkg, reachability_closure_engine_core and closure_watch.
module testbench;
    import rce_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data  = '0;

    int   mismatch_total;
    int   requests_open;
    int   quiet_cycles = 0;
    int   stall_left   = 0;
    logic calm         = 1'b0;
    int   live_n       = VERTEX_CAP;
    logic closed       = 1'b0;
    int   chain_end    = 0;

    always #6 clk = ~clk;

    reachability_closure_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    closure_watch watch (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_total (mismatch_total),
        .requests_open  (requests_open)
    );

    // Result backpressure: random stall bursts, none once calm
    always @(posedge clk)
    begin
        if (calm || !rst_n)
        begin
            stall_left = 0;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog: too long without any request moving on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // One request on the input stream, with an occasional gap ahead of it
    task automatic send_item(input mode_t md, input int a, input int b, input logic two);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, 6'(b), 6'(a)};
        s_tuser  <= {two, md};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Count writes only once the engine has drained and settled
    task automatic write_vertex_count(input logic [6:0] value);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (requests_open != 0);
        repeat (10) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (value == 7'd0)
            live_n = 1;
        else if (value > 7'(VERTEX_CAP))
            live_n = VERTEX_CAP;
        else
            live_n = int'(value);
        closed    = 1'b0;
        chain_end = 0;
    endtask

    // Mostly in range, sometimes anywhere in the 6-bit field
    function automatic int pick_vertex();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 63);
        return $urandom_range(0, live_n - 1);
    endfunction

    // Edges first, then a mix; queries only once a closure exists for this graph
    task automatic random_phase(input int items);
        int k;
        int pick;
        int a;
        int b;
        for (k = 0; k < items; k++)
        begin
            pick = $urandom_range(0, 99);
            if (k < 4 || (!closed && pick < 75) || (closed && pick >= 45 && pick < 80))
            begin
                // often extend a path so closures get deep
                a = ($urandom_range(0, 2) == 0) ? chain_end : pick_vertex();
                b = pick_vertex();
                chain_end = b;
                send_item(MODE_INSERT, a, b, 1'($urandom_range(0, 1)));
            end
            else if ((!closed && pick < 92) || (closed && pick >= 80 && pick < 93))
            begin
                send_item(MODE_CLOSE, $urandom_range(0, 63), $urandom_range(0, 63),
                          1'($urandom_range(0, 1)));
                closed = 1'b1;
            end
            else if (closed && pick < 45)
                send_item(MODE_QUERY, pick_vertex(), pick_vertex(), 1'($urandom_range(0, 1)));
            else
                send_item(MODE_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full 64-vertex graph from reset: duplicates, two-way edges, idle mode
        send_item(MODE_INSERT, 0, 63, 1'b1);
        send_item(MODE_INSERT, 63, 0, 1'b0);
        send_item(MODE_INSERT, 5, 6, 1'b0);
        send_item(MODE_INSERT, 6, 7, 1'b1);
        send_item(MODE_NONE, 63, 63, 1'b1);
        send_item(MODE_CLOSE, 0, 0, 1'b0);
        send_item(MODE_QUERY, 0, 63, 1'b0);
        send_item(MODE_QUERY, 5, 7, 1'b0);
        send_item(MODE_QUERY, 7, 5, 1'b1);
        send_item(MODE_QUERY, 42, 42, 1'b0);
        send_item(MODE_QUERY, 1, 2, 1'b0);

        // Three vertices: out of range inserts and queries
        write_vertex_count(7'd3);
        send_item(MODE_INSERT, 3, 0, 1'b0);
        send_item(MODE_INSERT, 0, 63, 1'b1);
        send_item(MODE_INSERT, 0, 1, 1'b1);
        send_item(MODE_INSERT, 1, 2, 1'b0);
        send_item(MODE_CLOSE, 0, 0, 1'b0);
        send_item(MODE_QUERY, 2, 0, 1'b0);
        send_item(MODE_QUERY, 0, 2, 1'b0);
        send_item(MODE_QUERY, 1, 3, 1'b0);

        // Zero count clamps to a single vertex
        write_vertex_count(7'd0);
        send_item(MODE_INSERT, 0, 0, 1'b1);
        send_item(MODE_CLOSE, 63, 63, 1'b1);
        send_item(MODE_QUERY, 0, 0, 1'b0);
        send_item(MODE_QUERY, 0, 1, 1'b0);
        closed = 1'b1;

        // Random graphs over a spread of sizes, the largest among them
        write_vertex_count(7'd2);
        random_phase(16);
        write_vertex_count(7'd5);
        random_phase(16);
        write_vertex_count(7'd127);
        random_phase(16);
        write_vertex_count(7'd9);
        random_phase(16);
        write_vertex_count(7'd16);
        random_phase(16);
        write_vertex_count(7'($urandom_range(1, 40)));
        random_phase(16);
        calm = 1'b1;
        write_vertex_count(7'd100);
        random_phase(16);
        write_vertex_count(7'd4);
        random_phase(16);

        // Drain, then leave room for anything stray
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (requests_open != 0);
        repeat (20) @(posedge clk);
        if (mismatch_total == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== reachability_closure_engine_core.f =====
+incdir+design
design/rce_pkg.sv
design/rce_ram.sv
design/rce_seq.sv
design/reachability_closure_engine_core.sv
design/rce_checker.sv
tb/sv/closure_watch.sv
tb/sv/testbench.sv
